// ===== rtl/core/rsw_pkg.sv =====
// Shared types and constants for the reservation station wakeup block.
package rsw_pkg;

   // Default sizes of the station.
   localparam int ENTRIES_DEF    = 8;
   localparam int TAG_BITS_DEF   = 5;
   localparam int VALUE_BITS_DEF = 32;

   // Fixed field widths of the request and response items.
   localparam int ID_BITS       = 16;
   localparam int OPC_BITS      = 8;
   localparam int SLOT_BITS     = 3;
   localparam int RSP_DATA_BITS = 8;

   // Item kinds carried on req_tuser.
   localparam logic KIND_DISPATCH  = 1'b0;
   localparam logic KIND_BROADCAST = 1'b1;

   // Controller states.
   typedef enum logic {
      RSW_IDLE,
      RSW_EXEC
   } rsw_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic execute;
   } rsw_cmd_type;

endpackage

// ===== rtl/core/rsw_ctrl.sv =====
// Controller state machine: request handshake, update sequencing and response valid.
module rsw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output rsw_pkg::rsw_cmd_type cmd
);
   import rsw_pkg::*;

   rsw_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= RSW_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_tready   = 1'b0;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         RSW_IDLE: begin
            // An item may be taken while an earlier response still waits.
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = RSW_EXEC;
            end
         end
         RSW_EXEC: begin
            // Update the entries once the response register can take the result.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.execute  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = RSW_IDLE;
            end
         end
         default: begin
            state_in = RSW_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/core/rsw_dpath.sv =====
// Datapath: item register, entry array with tag match and allocation, response register.
module rsw_dpath #(
   parameter int ENTRIES    = rsw_pkg::ENTRIES_DEF,
   parameter int TAG_BITS   = rsw_pkg::TAG_BITS_DEF,
   parameter int VALUE_BITS = rsw_pkg::VALUE_BITS_DEF,
   localparam int REQ_DATA_BITS =
      ((rsw_pkg::ID_BITS + rsw_pkg::OPC_BITS + 4 * TAG_BITS + 3 * VALUE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  rsw_pkg::rsw_cmd_type               cmd,
   input  logic [REQ_DATA_BITS-1:0]           req_tdata,
   input  logic                               req_tuser,
   output logic [rsw_pkg::RSP_DATA_BITS-1:0]  rsp_tdata
);
   import rsw_pkg::*;

   localparam int IDX_BITS = $clog2(ENTRIES);

   // Bit offsets of the request fields in tdata.
   localparam int OFF_ID    = 0;
   localparam int OFF_OP    = OFF_ID + ID_BITS;
   localparam int OFF_DEST  = OFF_OP + OPC_BITS;
   localparam int OFF_S1T   = OFF_DEST + TAG_BITS;
   localparam int OFF_S1V   = OFF_S1T + TAG_BITS;
   localparam int OFF_S2T   = OFF_S1V + VALUE_BITS;
   localparam int OFF_S2V   = OFF_S2T + TAG_BITS;
   localparam int OFF_BT    = OFF_S2V + VALUE_BITS;
   localparam int OFF_BV    = OFF_BT + TAG_BITS;

   // Held request item.
   logic                         kind_ff;
   logic [ID_BITS-1:0]           inst_id_ff;
   logic [OPC_BITS-1:0]          inst_op_ff;
   logic [TAG_BITS-1:0]          dst_tag_ff, opa_tag_ff, opb_tag_ff, bcast_tag_ff;
   logic signed [VALUE_BITS-1:0] opa_value_ff, opb_value_ff, bcast_value_ff;

   // Entry storage.
   logic [ENTRIES-1:0]           valid_ff, valid_in;
   logic [ID_BITS-1:0]           e_id_ff [ENTRIES];
   logic [ID_BITS-1:0]           e_id_in [ENTRIES];
   logic [OPC_BITS-1:0]          e_op_ff [ENTRIES];
   logic [OPC_BITS-1:0]          e_op_in [ENTRIES];
   logic [TAG_BITS-1:0]          e_dest_ff [ENTRIES];
   logic [TAG_BITS-1:0]          e_dest_in [ENTRIES];
   logic [TAG_BITS-1:0]          e_s1t_ff [ENTRIES];
   logic [TAG_BITS-1:0]          e_s1t_in [ENTRIES];
   logic [TAG_BITS-1:0]          e_s2t_ff [ENTRIES];
   logic [TAG_BITS-1:0]          e_s2t_in [ENTRIES];
   logic signed [VALUE_BITS-1:0] e_s1v_ff [ENTRIES];
   logic signed [VALUE_BITS-1:0] e_s1v_in [ENTRIES];
   logic signed [VALUE_BITS-1:0] e_s2v_ff [ENTRIES];
   logic signed [VALUE_BITS-1:0] e_s2v_in [ENTRIES];

   logic                         have_free;
   logic [IDX_BITS-1:0]          free_idx;
   logic                         is_dispatch, is_bcast, alloc;
   logic [IDX_BITS+SLOT_BITS-1:0] slot_wide;
   logic [RSP_DATA_BITS-1:0]     rsp_in, rsp_ff;

   // Capture the accepted request.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff        <= req_tuser;
         inst_id_ff     <= req_tdata[OFF_ID +: ID_BITS];
         inst_op_ff     <= req_tdata[OFF_OP +: OPC_BITS];
         dst_tag_ff     <= req_tdata[OFF_DEST +: TAG_BITS];
         opa_tag_ff     <= req_tdata[OFF_S1T +: TAG_BITS];
         opa_value_ff   <= req_tdata[OFF_S1V +: VALUE_BITS];
         opb_tag_ff     <= req_tdata[OFF_S2T +: TAG_BITS];
         opb_value_ff   <= req_tdata[OFF_S2V +: VALUE_BITS];
         bcast_tag_ff   <= req_tdata[OFF_BT +: TAG_BITS];
         bcast_value_ff <= req_tdata[OFF_BV +: VALUE_BITS];
      end
   end

   // Lowest-numbered free entry.
   always_comb begin
      have_free = 1'b0;
      free_idx  = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         if (!valid_ff[i] && !have_free) begin
            have_free = 1'b1;
            free_idx  = IDX_BITS'(i);
         end
      end
   end

   assign is_dispatch = (kind_ff == KIND_DISPATCH);
   assign is_bcast    = (kind_ff == KIND_BROADCAST) && (bcast_tag_ff != '0);
   assign alloc       = is_dispatch && have_free;

   // Per-entry update: allocation on dispatch, free and wakeup on broadcast.
   always_comb begin
      for (int i = 0; i < ENTRIES; i++) begin
         valid_in[i]  = valid_ff[i];
         e_id_in[i]   = e_id_ff[i];
         e_op_in[i]   = e_op_ff[i];
         e_dest_in[i] = e_dest_ff[i];
         e_s1t_in[i]  = e_s1t_ff[i];
         e_s1v_in[i]  = e_s1v_ff[i];
         e_s2t_in[i]  = e_s2t_ff[i];
         e_s2v_in[i]  = e_s2v_ff[i];
         if (alloc && (free_idx == IDX_BITS'(i))) begin
            valid_in[i]  = 1'b1;
            e_id_in[i]   = inst_id_ff;
            e_op_in[i]   = inst_op_ff;
            e_dest_in[i] = dst_tag_ff;
            e_s1t_in[i]  = opa_tag_ff;
            e_s1v_in[i]  = opa_value_ff;
            e_s2t_in[i]  = opb_tag_ff;
            e_s2v_in[i]  = opb_value_ff;
         end else if (is_bcast && valid_ff[i]) begin
            if (e_dest_ff[i] == bcast_tag_ff) begin
               // The producing instruction has completed: release its entry.
               valid_in[i] = 1'b0;
            end else begin
               if (e_s1t_ff[i] == bcast_tag_ff) begin
                  e_s1t_in[i] = '0;
                  e_s1v_in[i] = bcast_value_ff;
               end
               if (e_s2t_ff[i] == bcast_tag_ff) begin
                  e_s2t_in[i] = '0;
                  e_s2v_in[i] = bcast_value_ff;
               end
            end
         end
      end
   end

   // Entry control state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         for (int i = 0; i < ENTRIES; i++) begin
            e_dest_ff[i] <= '0;
            e_s1t_ff[i]  <= '0;
            e_s2t_ff[i]  <= '0;
         end
      end else if (cmd.execute) begin
         valid_ff <= valid_in;
         for (int i = 0; i < ENTRIES; i++) begin
            e_dest_ff[i] <= e_dest_in[i];
            e_s1t_ff[i]  <= e_s1t_in[i];
            e_s2t_ff[i]  <= e_s2t_in[i];
         end
      end
   end

   // Entry payload, written only through allocation and wakeup.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < ENTRIES; i++) begin
            e_id_ff[i]  <= e_id_in[i];
            e_op_ff[i]  <= e_op_in[i];
            e_s1v_ff[i] <= e_s1v_in[i];
            e_s2v_ff[i] <= e_s2v_in[i];
         end
      end
   end

   // Response fields, taken from the entry state after the update.
   assign slot_wide = {{SLOT_BITS{1'b0}}, free_idx};

   always_comb begin
      rsp_in    = '0;
      rsp_in[0] = is_dispatch && !have_free;
      rsp_in[SLOT_BITS:1] = alloc ? slot_wide[SLOT_BITS-1:0] : '0;
      rsp_in[SLOT_BITS+1] = ~&valid_in;
      rsp_in[SLOT_BITS+2] = |valid_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tdata = rsp_ff;

endmodule

// ===== rtl/core/reservation_station_wakeup.sv =====
// Top level of the reservation station wakeup block.
//
// A reservation station of ENTRIES entries. Each request transfer is either a dispatch
// (req_tuser low), which writes the instruction into the lowest-numbered free entry, or a
// result broadcast (req_tuser high), which frees every valid entry whose destination tag
// matches and wakes every source operand waiting on that tag; broadcast tag zero matches
// nothing. Every request gives exactly one response transfer with the drop flag, the
// allocated slot and the vacancy and busy flags after the update. Each item is first taken
// into the item register, and then the tag compare and allocation logic updates all entries
// in parallel; no new request is taken until that update is done. A new request is taken
// while the previous response still waits, and the update waits only while the response
// register is full. Entries come up empty right after reset; there is no clearing pass.
module reservation_station_wakeup #(
   parameter int ENTRIES    = rsw_pkg::ENTRIES_DEF,
   parameter int TAG_BITS   = rsw_pkg::TAG_BITS_DEF,
   parameter int VALUE_BITS = rsw_pkg::VALUE_BITS_DEF,
   localparam int REQ_DATA_BITS =
      ((rsw_pkg::ID_BITS + rsw_pkg::OPC_BITS + 4 * TAG_BITS + 3 * VALUE_BITS + 7) / 8) * 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // inst_id, inst_op, dst_tag, opa_tag, opa_value, opb_tag, opb_value,
   // bcast_tag, bcast_value, zero fill
   input  logic [REQ_DATA_BITS-1:0]          req_tdata,
   // item kind: dispatch (low) or broadcast (high)
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status, slot, has_vacancy, any_busy, zero fill
   output logic [rsw_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import rsw_pkg::*;

   rsw_cmd_type cmd;

   rsw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   rsw_dpath #(
      .ENTRIES    (ENTRIES),
      .TAG_BITS   (TAG_BITS),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata)
   );

   // A dropped dispatch means every entry was busy.
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> !rsp_tdata[SLOT_BITS+1] && rsp_tdata[SLOT_BITS+2])
      else $error("dropped dispatch reported with a free entry");

   // A dropped dispatch reports slot zero.
   a_drop_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[0] |-> rsp_tdata[SLOT_BITS:1] == '0)
      else $error("dropped dispatch reported a nonzero slot");

   // A station with no vacancy must have busy entries.
   a_full_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[SLOT_BITS+1] |-> rsp_tdata[SLOT_BITS+2])
      else $error("no vacancy reported while no entry is busy");

   // In the cycle after a request transfer the block is busy with the update and takes no request.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while the previous update is pending");

endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench for the reservation station wakeup block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import rsw_pkg::*;

   localparam int ENTRIES  = ENTRIES_DEF;
   localparam int TAG_W    = TAG_BITS_DEF;
   localparam int VAL_W    = VALUE_BITS_DEF;
   localparam int REQ_BITS = ((ID_BITS + OPC_BITS + 4 * TAG_W + 3 * VAL_W + 7) / 8) * 8;
   localparam int CYCLE_LIMIT = 200000;

   // One request item with every field of both kinds.
   typedef struct {
      logic                    kind;
      logic [ID_BITS-1:0]      inst_id;
      logic [OPC_BITS-1:0]     inst_op;
      logic [TAG_W-1:0]        dst_tag;
      logic [TAG_W-1:0]        opa_tag;
      logic signed [VAL_W-1:0] opa_value;
      logic [TAG_W-1:0]        opb_tag;
      logic signed [VAL_W-1:0] opb_value;
      logic [TAG_W-1:0]        bcast_tag;
      logic signed [VAL_W-1:0] bcast_value;
   } rs_item_type;

   // One response item.
   typedef struct packed {
      logic                 dropped;
      logic [SLOT_BITS-1:0] slot;
      logic                 vacancy;
      logic                 busy;
   } outcome_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   // inst_id, inst_op, dst_tag, opa_tag, opa_value, opb_tag, opb_value,
   // bcast_tag, bcast_value, zero fill
   logic [REQ_BITS-1:0]      req_tdata  = '0;
   // item kind: dispatch (low) or broadcast (high)
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // status, slot, has_vacancy, any_busy, zero fill
   logic [RSP_DATA_BITS-1:0] rsp_tdata;

   // Occupancy of the station as predicted. Source readiness never reaches the
   // response, so only the valid bits and destination tags are tracked.
   logic [ENTRIES-1:0]       slot_busy = '0;
   logic [TAG_W-1:0]         slot_dest [ENTRIES];

   outcome_type pending_outcomes[$];
   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int error_count        = 0;
   int requests_sent      = 0;
   int dispatches_dropped = 0;
   int entries_freed      = 0;
   int cycle_count        = 0;

   reservation_station_wakeup dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #1 clock = ~clock;

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped: cycle limit reached with %0d responses outstanding.",
                  pending_outcomes.size());
         $display("FAIL");
         $finish;
      end
   end

   function automatic int lowest_free_slot();
      for (int i = 0; i < ENTRIES; i++)
         if (!slot_busy[i])
            return i;
      return -1;
   endfunction

   // Applies one accepted item to the predicted station and returns its response.
   function automatic outcome_type station_outcome(input rs_item_type it);
      outcome_type o;
      int          free_idx;
      o = '0;
      if (it.kind == KIND_DISPATCH) begin
         free_idx = lowest_free_slot();
         if (free_idx < 0) begin
            o.dropped = 1'b1;
            dispatches_dropped++;
         end else begin
            slot_busy[free_idx] = 1'b1;
            slot_dest[free_idx] = it.dst_tag;
            o.slot = SLOT_BITS'(free_idx);
         end
      end else if (it.bcast_tag != '0) begin
         // A matching destination frees the entry; tag zero matches nothing.
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_busy[i] && slot_dest[i] == it.bcast_tag) begin
               slot_busy[i] = 1'b0;
               entries_freed++;
            end
         end
      end
      o.vacancy = (lowest_free_slot() >= 0);
      o.busy    = |slot_busy;
      return o;
   endfunction

   function automatic logic [REQ_BITS-1:0] pack_request(input rs_item_type it);
      logic [REQ_BITS-1:0] r;
      r = '0;
      r[ID_BITS + OPC_BITS + 4 * TAG_W + 3 * VAL_W - 1:0] =
         {it.bcast_value, it.bcast_tag, it.opb_value, it.opb_tag, it.opa_value,
          it.opa_tag, it.dst_tag, it.inst_op, it.inst_id};
      return r;
   endfunction

   // Mostly uniform values, with the extremes now and then.
   function automatic logic [VAL_W-1:0] random_value();
      case ($urandom_range(9))
         0: return {1'b1, {(VAL_W-1){1'b0}}};
         1: return {1'b0, {(VAL_W-1){1'b1}}};
         2: return '1;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   // Fields of the other kind carry random noise.
   function automatic rs_item_type make_dispatch(input logic [ID_BITS-1:0] id,
                                                 input logic [OPC_BITS-1:0] op,
                                                 input logic [TAG_W-1:0] dest,
                                                 input logic [TAG_W-1:0] s1_tag,
                                                 input logic [VAL_W-1:0] s1_value,
                                                 input logic [TAG_W-1:0] s2_tag,
                                                 input logic [VAL_W-1:0] s2_value);
      rs_item_type it;
      it.kind        = KIND_DISPATCH;
      it.inst_id     = id;
      it.inst_op     = op;
      it.dst_tag     = dest;
      it.opa_tag     = s1_tag;
      it.opa_value   = s1_value;
      it.opb_tag     = s2_tag;
      it.opb_value   = s2_value;
      it.bcast_tag   = TAG_W'($urandom);
      it.bcast_value = random_value();
      return it;
   endfunction

   function automatic rs_item_type make_broadcast(input logic [TAG_W-1:0] tag,
                                                  input logic [VAL_W-1:0] value);
      rs_item_type it;
      it = make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom), TAG_W'($urandom),
                         TAG_W'($urandom), random_value(), TAG_W'($urandom),
                         random_value());
      it.kind        = KIND_BROADCAST;
      it.bcast_tag   = tag;
      it.bcast_value = value;
      return it;
   endfunction

   // Presents one item, holds it until the transfer, and records its response.
   task automatic send_item(input rs_item_type it);
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= pack_request(it);
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(station_outcome(it));
      requests_sent++;
   endtask

   // Holds the sender until every expected response has come back.
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Receiver: checks each response transfer, then picks the next ready level.
   always @(posedge clock) begin
      outcome_type exp_o;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            $error("Response 0x%h arrived with no request outstanding.", rsp_tdata);
            error_count++;
         end else begin
            exp_o = pending_outcomes.pop_front();
            if (rsp_tdata[0] !== exp_o.dropped) begin
               $error("status: expected %0d, got %0d", exp_o.dropped, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[3:1] !== exp_o.slot) begin
               $error("slot: expected %0d, got %0d", exp_o.slot, rsp_tdata[3:1]);
               error_count++;
            end
            if (rsp_tdata[4] !== exp_o.vacancy) begin
               $error("has_vacancy: expected %0d, got %0d", exp_o.vacancy, rsp_tdata[4]);
               error_count++;
            end
            if (rsp_tdata[5] !== exp_o.busy) begin
               $error("any_busy: expected %0d, got %0d", exp_o.busy, rsp_tdata[5]);
               error_count++;
            end
         end
      end
      rsp_tready <= (receiver_stall_pct == 0) || ($urandom_range(99) >= receiver_stall_pct);
   end

   // Broadcasts the destination tag of every busy entry until the station is empty.
   // Entries with destination tag zero can never be freed and are left alone.
   task automatic flush_station();
      for (int i = 0; i < ENTRIES; i++)
         if (slot_busy[i] && slot_dest[i] != '0)
            send_item(make_broadcast(slot_dest[i], random_value()));
   endtask

   // Field extremes on dispatch, including waiting sources that carry a value
   // and an absent second source.
   task automatic test_dispatch_fields();
      send_item(make_dispatch('0, '0, TAG_W'(1), '0, {1'b1, {(VAL_W-1){1'b0}}}, '0, '0));
      send_item(make_dispatch('1, '1, '1, '1, {1'b0, {(VAL_W-1){1'b1}}}, '1, '1));
      send_item(make_dispatch(16'h5a5a, 8'ha5, TAG_W'(2), TAG_W'(1), random_value(),
                              '0, '0));
   endtask

   // Fills the remaining entries, then two dispatches hit a full station.
   task automatic test_fill_and_overflow();
      for (int t = 2; t <= 6; t++)
         send_item(make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom), TAG_W'(t),
                                 TAG_W'(t - 1), random_value(), '0, random_value()));
      repeat (2)
         send_item(make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom), TAG_W'(9),
                                 '0, random_value(), '0, '0));
   endtask

   // Broadcast tag zero matches nothing, even with entries busy.
   task automatic test_broadcast_tag_zero();
      send_item(make_broadcast('0, random_value()));
   endtask

   // One broadcast freeing two entries that share a tag, single frees, a miss,
   // refill into the lowest free slot, then an empty station.
   task automatic test_broadcast_wakeup();
      send_item(make_broadcast(TAG_W'(2), random_value()));
      send_item(make_broadcast(TAG_W'(1), {1'b1, {(VAL_W-1){1'b0}}}));
      send_item(make_broadcast('1, '1));
      send_item(make_broadcast(TAG_W'(20), random_value()));
      send_item(make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom), TAG_W'(7),
                              TAG_W'(3), random_value(), TAG_W'(4), random_value()));
      flush_station();
   endtask

   // Random traffic: mostly dispatches and broadcasts that target live tags,
   // with a few broadcasts to stray tags.
   task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct);
      rs_item_type it;
      int          busy_n;
      int          pick;
      int          dispatch_pct;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      for (int n = 0; n < count; n++) begin
         busy_n = $countones(slot_busy);
         dispatch_pct = (busy_n == ENTRIES) ? 30 : (busy_n == 0) ? 80 : 50;
         if ($urandom_range(99) < dispatch_pct) begin
            it = make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom),
                               ($urandom_range(1) != 0) ? TAG_W'($urandom_range(1, 4))
                                                        : TAG_W'($urandom_range(1, 31)),
                               ($urandom_range(9) < 4) ? '0 : TAG_W'($urandom),
                               random_value(), '0, '0);
            if ($urandom_range(3) != 0) begin
               it.opb_tag   = ($urandom_range(9) < 4) ? '0 : TAG_W'($urandom);
               it.opb_value = random_value();
            end
         end else begin
            it = make_broadcast(TAG_W'($urandom), random_value());
            if (busy_n != 0 && $urandom_range(3) != 0) begin
               pick = $urandom_range(ENTRIES - 1);
               while (!slot_busy[pick])
                  pick = (pick + 1) % ENTRIES;
               it.bcast_tag = slot_dest[pick];
            end
         end
         send_item(it);
      end
      drain_responses();
   endtask

   // A destination tag of zero stays busy through every broadcast.
   task automatic test_dest_tag_zero();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      flush_station();
      send_item(make_dispatch(ID_BITS'($urandom), OPC_BITS'($urandom), '0, '0,
                              random_value(), '0, '0));
      send_item(make_broadcast('0, random_value()));
      send_item(make_broadcast(TAG_W'($urandom_range(1, 31)), random_value()));
      drain_responses();
   endtask

   // Test sequence.
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_dispatch_fields();
      test_fill_and_overflow();
      test_broadcast_tag_zero();
      test_broadcast_wakeup();
      drain_responses();

      run_random_phase(240, 0, 0);
      run_random_phase(235, 75, 0);
      run_random_phase(235, 0, 75);
      run_random_phase(240, 31, 31);

      test_dest_tag_zero();
      repeat (10) @(posedge clock);

      $display("Sent %0d requests; %0d dispatches were dropped on a full station and",
               requests_sent, dispatches_dropped);
      $display("%0d entries were freed by broadcast, under gaps and stalls on both sides.",
               entries_freed);
      if (error_count == 0 && pending_outcomes.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/rsw_pkg.sv
rtl/core/rsw_ctrl.sv
rtl/core/rsw_dpath.sv
rtl/core/reservation_station_wakeup.sv
bench/testbench.sv
